// ----- hw/rtl/iss_pkg.sv -----
`default_nettype none

package iss_pkg;

   // storage geometry
   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 64;
   localparam int ACT_W  = 3;
   localparam int ERR_W  = 2;

   // capacity limit after reset
   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(50);

   // action codes
   localparam logic [ACT_W-1:0] ACT_PUSH  = 3'd0;
   localparam logic [ACT_W-1:0] ACT_POP   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_READ  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_WRITE = 3'd3;
   localparam logic [ACT_W-1:0] ACT_FIND  = 3'd4;
   localparam logic [ACT_W-1:0] ACT_SWAP  = 3'd5;

   // error codes
   localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;
   localparam logic [ERR_W-1:0] ERR_RANGE = 2'd3;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_FIND,
      ST_SWAP_A,
      ST_SWAP_B,
      ST_SWAP_C,
      ST_DONE
   } state_type;

   // memory request from the sequencer
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [DATA_W-1:0] wdata;
      logic [ADDR_W-1:0] raddr;
   } ram_req_type;

endpackage

`default_nettype wire

// ----- hw/rtl/iss_ram.sv -----
`default_nettype none

module iss_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/iss_seq.sv -----
`default_nettype none

module iss_seq (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [iss_pkg::CNT_W-1:0]     cap_limit,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [iss_pkg::ACT_W-1:0]     req_action,
   input  wire logic [iss_pkg::ADDR_W-1:0]    req_index_a,
   input  wire logic [iss_pkg::ADDR_W-1:0]    req_index_b,
   input  wire logic [iss_pkg::DATA_W-1:0]    req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [iss_pkg::DATA_W-1:0]    rsp_read_value,
   output logic                               rsp_found,
   output logic      [iss_pkg::ADDR_W-1:0]    rsp_found_index,
   output logic      [iss_pkg::CNT_W-1:0]     rsp_fill_count,
   output logic      [iss_pkg::ERR_W-1:0]     rsp_error,
   output iss_pkg::ram_req_type               ram_req,
   input  wire logic [iss_pkg::DATA_W-1:0]    ram_rdata
);

   import iss_pkg::*;

   state_type         state_ff, state_in;
   logic [ACT_W-1:0]  act_ff, act_in;
   logic [ADDR_W-1:0] ia_ff, ia_in;
   logic [ADDR_W-1:0] ib_ff, ib_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [DATA_W-1:0] tmp_ff, tmp_in;
   logic [DATA_W-1:0] rd_ff, rd_in;
   logic              fnd_ff, fnd_in;
   logic [ADDR_W-1:0] fidx_ff, fidx_in;
   logic [ERR_W-1:0]  err_ff, err_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_rd_ff, rsp_rd_in;
   logic              rsp_fnd_ff, rsp_fnd_in;
   logic [ADDR_W-1:0] rsp_fidx_ff, rsp_fidx_in;
   logic [CNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;
   logic [ERR_W-1:0]  rsp_err_ff, rsp_err_in;

   logic [CNT_W-1:0]  eff_limit;
   logic [CNT_W-1:0]  cnt_dec;
   logic [CNT_W-1:0]  ptr_nxt;
   logic              a_out;
   logic              b_out;
   logic              word_eq;

   // push limit capped at the store depth
   assign eff_limit = (cap_limit > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_limit;
   assign cnt_dec   = cnt_ff - CNT_W'(1);
   assign ptr_nxt   = {1'b0, ptr_ff} + CNT_W'(1);
   assign a_out     = ({1'b0, ia_ff} >= cnt_ff);
   assign b_out     = ({1'b0, ib_ff} >= cnt_ff);

   // single 64-bit comparator for the search walk
   assign word_eq   = (ram_rdata == val_ff);

   // state and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff      <= act_in;
      ia_ff       <= ia_in;
      ib_ff       <= ib_in;
      val_ff      <= val_in;
      ptr_ff      <= ptr_in;
      tmp_ff      <= tmp_in;
      rd_ff       <= rd_in;
      fnd_ff      <= fnd_in;
      fidx_ff     <= fidx_in;
      err_ff      <= err_in;
      rsp_rd_ff   <= rsp_rd_in;
      rsp_fnd_ff  <= rsp_fnd_in;
      rsp_fidx_ff <= rsp_fidx_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_err_ff  <= rsp_err_in;
   end

   // next state, memory requests and result collection
   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      ia_in        = ia_ff;
      ib_in        = ib_ff;
      val_in       = val_ff;
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      tmp_in       = tmp_ff;
      rd_in        = rd_ff;
      fnd_in       = fnd_ff;
      fidx_in      = fidx_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_rd_in    = rsp_rd_ff;
      rsp_fnd_in   = rsp_fnd_ff;
      rsp_fidx_in  = rsp_fidx_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_err_in   = rsp_err_ff;
      req_ready    = 1'b0;
      ram_req      = '{we: 1'b0, waddr: ia_ff, wdata: val_ff, raddr: ia_ff};

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               act_in   = req_action;
               ia_in    = req_index_a;
               ib_in    = req_index_b;
               val_in   = req_value;
               rd_in    = '0;
               fnd_in   = 1'b0;
               fidx_in  = '0;
               err_in   = ERR_OK;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            state_in = ST_DONE;
            unique case (act_ff)
               ACT_PUSH: begin
                  if (cnt_ff >= eff_limit) begin
                     err_in = ERR_FULL;
                  end else begin
                     ram_req.we    = 1'b1;
                     ram_req.waddr = cnt_ff[ADDR_W-1:0];
                     cnt_in        = cnt_ff + CNT_W'(1);
                  end
               end
               ACT_POP: begin
                  if (cnt_ff == '0) begin
                     err_in = ERR_EMPTY;
                  end else begin
                     ram_req.we    = 1'b1;
                     ram_req.waddr = cnt_dec[ADDR_W-1:0];
                     ram_req.wdata = '0;
                     cnt_in        = cnt_dec;
                  end
               end
               ACT_READ: begin
                  if (a_out) begin
                     err_in = ERR_RANGE;
                  end else begin
                     state_in = ST_READ;
                  end
               end
               ACT_WRITE: begin
                  if (a_out) begin
                     err_in = ERR_RANGE;
                  end else begin
                     ram_req.we = 1'b1;
                  end
               end
               ACT_FIND: begin
                  ram_req.raddr = '0;
                  ptr_in        = '0;
                  if (cnt_ff != '0) begin
                     state_in = ST_FIND;
                  end
               end
               ACT_SWAP: begin
                  if (a_out || b_out) begin
                     err_in = ERR_RANGE;
                  end else begin
                     state_in = ST_SWAP_A;
                  end
               end
               default: begin
               end
            endcase
         end

         // read data of index a is now on the port
         ST_READ: begin
            rd_in    = ram_rdata;
            state_in = ST_DONE;
         end

         // one entry compared per cycle, next address already issued
         ST_FIND: begin
            ram_req.raddr = ptr_nxt[ADDR_W-1:0];
            if (word_eq) begin
               fnd_in   = 1'b1;
               fidx_in  = ptr_ff;
               state_in = ST_DONE;
            end else if (ptr_nxt >= cnt_ff) begin
               state_in = ST_DONE;
            end else begin
               ptr_in = ptr_nxt[ADDR_W-1:0];
            end
         end

         // hold entry a, fetch entry b
         ST_SWAP_A: begin
            tmp_in        = ram_rdata;
            ram_req.raddr = ib_ff;
            state_in      = ST_SWAP_B;
         end

         ST_SWAP_B: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = ia_ff;
            ram_req.wdata = ram_rdata;
            state_in      = ST_SWAP_C;
         end

         ST_SWAP_C: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = ib_ff;
            ram_req.wdata = tmp_ff;
            state_in      = ST_DONE;
         end

         // hand the result to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_rd_in    = rd_ff;
               rsp_fnd_in   = fnd_ff;
               rsp_fidx_in  = fidx_ff;
               rsp_cnt_in   = cnt_ff;
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_rd_ff;
   assign rsp_found       = rsp_fnd_ff;
   assign rsp_found_index = rsp_fidx_ff;
   assign rsp_fill_count  = rsp_cnt_ff;
   assign rsp_error       = rsp_err_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond store depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new transaction taken while one is in progress");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      ram_req.we |-> (state_ff == ST_EXEC || state_ff == ST_SWAP_B ||
                      state_ff == ST_SWAP_C))
      else $error("memory write outside a writing state");

   a_found_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> ({1'b0, rsp_found_index} < rsp_fill_count))
      else $error("found index not below fill count");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff && rsp_valid_in |-> state_ff == ST_DONE)
      else $error("result loaded outside the done state");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/indexed_stack_store_with_search.sv -----
// sequence: push, pop, write and failed actions pass the execute and done states; read
//   adds the read state, swap the three swap states, find one find state per entry up
//   to the match or the fill count; done waits while the output register is held
// throughput: one transaction at a time, next one accepted the cycle after the result
//   enters the output register
// reset: synchronous, fill count zero, capacity limit 50, store contents kept
`default_nettype none

module indexed_stack_store_with_search (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [iss_pkg::CNT_W-1:0]     csr_capacity_limit,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [iss_pkg::ACT_W-1:0]     req_action,
   input  wire logic [iss_pkg::ADDR_W-1:0]    req_index_a,
   input  wire logic [iss_pkg::ADDR_W-1:0]    req_index_b,
   input  wire logic [iss_pkg::DATA_W-1:0]    req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [iss_pkg::DATA_W-1:0]    rsp_read_value,
   output logic                               rsp_found,
   output logic      [iss_pkg::ADDR_W-1:0]    rsp_found_index,
   output logic      [iss_pkg::CNT_W-1:0]     rsp_fill_count,
   output logic      [iss_pkg::ERR_W-1:0]     rsp_error
);

   import iss_pkg::*;

   logic [CNT_W-1:0]  cap_ff, cap_in;
   ram_req_type       ram_req;
   logic [DATA_W-1:0] ram_rdata;

   // capacity limit register
   assign csr_ready = 1'b1;
   assign cap_in    = (csr_valid && csr_ready) ? csr_capacity_limit : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   // entry store
   iss_ram #(
      .WIDTH(DATA_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock(clock),
      .we   (ram_req.we),
      .waddr(ram_req.waddr),
      .wdata(ram_req.wdata),
      .raddr(ram_req.raddr),
      .rdata(ram_rdata)
   );

   // action sequencer
   iss_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .cap_limit      (cap_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_index_a    (req_index_a),
      .req_index_b    (req_index_b),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_value (rsp_read_value),
      .rsp_found      (rsp_found),
      .rsp_found_index(rsp_found_index),
      .rsp_fill_count (rsp_fill_count),
      .rsp_error      (rsp_error),
      .ram_req        (ram_req),
      .ram_rdata      (ram_rdata)
   );

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import iss_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 100;
   localparam int SEGMENT_ITEMS = 150;
   localparam int PRINT_LIMIT   = 100;

   // one request transaction as the block sees it
   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [ADDR_W-1:0] index_a;
      logic [ADDR_W-1:0] index_b;
      logic [DATA_W-1:0] value;
   } stack_req_type;

   // one response transaction
   typedef struct packed {
      logic [DATA_W-1:0] read_value;
      logic              found;
      logic [ADDR_W-1:0] found_index;
      logic [CNT_W-1:0]  fill_count;
      logic [ERR_W-1:0]  error;
   } stack_rsp_type;

   typedef enum logic [1:0] {ENTRY_REQ, ENTRY_CSR, ENTRY_MODE} entry_kind_type;

   // work for the driver: a request, a limit write or a change of idling
   typedef struct packed {
      entry_kind_type kind;
      stack_req_type  req;
      logic [CNT_W-1:0] limit;
      logic [6:0]     send_idle;
      logic [6:0]     recv_stall;
   } pending_type;

   logic clock;
   logic reset = 1'b1;

   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CNT_W-1:0]    csr_capacity_limit = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [ACT_W-1:0]    req_action = '0;
   logic [ADDR_W-1:0]   req_index_a = '0;
   logic [ADDR_W-1:0]   req_index_b = '0;
   logic [DATA_W-1:0]   req_value = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [DATA_W-1:0]   rsp_read_value;
   logic                rsp_found;
   logic [ADDR_W-1:0]   rsp_found_index;
   logic [CNT_W-1:0]    rsp_fill_count;
   logic [ERR_W-1:0]    rsp_error;

   // mirror of the block state
   logic [DATA_W-1:0]   mirror_words [DEPTH];
   logic [CNT_W-1:0]    mirror_count = '0;
   logic [CNT_W-1:0]    mirror_limit = CAP_RESET;

   // generator-side view of the fill count, used to aim indexes
   int                  plan_count = 0;
   int                  plan_limit = 50;
   logic [DATA_W-1:0]   hot_values [8];

   pending_type         pending_items [$];
   stack_rsp_type       awaited_responses [$];
   int                  open_requests = 0;
   int                  mismatch_count = 0;
   int                  cycle_count = 0;
   logic [6:0]          send_idle_pct = '0;
   logic [6:0]          recv_stall_pct = '0;

   indexed_stack_store_with_search i_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_capacity_limit (csr_capacity_limit),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_index_a        (req_index_a),
      .req_index_b        (req_index_b),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_read_value     (rsp_read_value),
      .rsp_found          (rsp_found),
      .rsp_found_index    (rsp_found_index),
      .rsp_fill_count     (rsp_fill_count),
      .rsp_error          (rsp_error)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("%0t ns mismatch: %s", $time, msg);
      end
   endtask

   // apply one action to the mirror and return the response it gives
   function automatic stack_rsp_type stack_apply(input stack_req_type r);
      stack_rsp_type    o;
      logic [CNT_W-1:0] cap;
      logic [DATA_W-1:0] tmp;
      int i;
      o = '0;
      cap = (mirror_limit > DEPTH) ? CNT_W'(DEPTH) : mirror_limit;
      case (r.action)
         ACT_PUSH: begin
            if (mirror_count >= cap) begin
               o.error = ERR_FULL;
            end else begin
               mirror_words[mirror_count[ADDR_W-1:0]] = r.value;
               mirror_count = mirror_count + 1'b1;
            end
         end
         ACT_POP: begin
            if (mirror_count == 0) begin
               o.error = ERR_EMPTY;
            end else begin
               mirror_count = mirror_count - 1'b1;
               mirror_words[mirror_count[ADDR_W-1:0]] = '0;
            end
         end
         ACT_READ: begin
            if (r.index_a >= mirror_count) o.error = ERR_RANGE;
            else o.read_value = mirror_words[r.index_a];
         end
         ACT_WRITE: begin
            if (r.index_a >= mirror_count) o.error = ERR_RANGE;
            else mirror_words[r.index_a] = r.value;
         end
         ACT_FIND: begin
            for (i = 0; i < mirror_count; i++) begin
               if (!o.found && mirror_words[ADDR_W'(i)] == r.value) begin
                  o.found = 1'b1;
                  o.found_index = ADDR_W'(i);
               end
            end
         end
         ACT_SWAP: begin
            if (r.index_a >= mirror_count || r.index_b >= mirror_count) begin
               o.error = ERR_RANGE;
            end else begin
               tmp = mirror_words[r.index_b];
               mirror_words[r.index_b] = mirror_words[r.index_a];
               mirror_words[r.index_a] = tmp;
            end
         end
         default: ;
      endcase
      o.fill_count = mirror_count;
      return o;
   endfunction

   function automatic void add_request(input logic [ACT_W-1:0] action,
                                       input logic [ADDR_W-1:0] ia,
                                       input logic [ADDR_W-1:0] ib,
                                       input logic [DATA_W-1:0] value);
      pending_type p;
      int cap;
      p = '0;
      p.kind = ENTRY_REQ;
      p.req.action = action;
      p.req.index_a = ia;
      p.req.index_b = ib;
      p.req.value = value;
      pending_items = {pending_items, p};
      cap = (plan_limit > DEPTH) ? DEPTH : plan_limit;
      if (action == ACT_PUSH && plan_count < cap) plan_count++;
      else if (action == ACT_POP && plan_count != 0) plan_count--;
   endfunction

   function automatic void add_limit(input logic [CNT_W-1:0] limit);
      pending_type p;
      p = '0;
      p.kind = ENTRY_CSR;
      p.limit = limit;
      pending_items = {pending_items, p};
      plan_limit = limit;
   endfunction

   function automatic void add_mode(input logic [6:0] send_idle, input logic [6:0] recv_stall);
      pending_type p;
      p = '0;
      p.kind = ENTRY_MODE;
      p.send_idle = send_idle;
      p.recv_stall = recv_stall;
      pending_items = {pending_items, p};
   endfunction

   // mostly live entries, sometimes the first free slot, sometimes anything
   function automatic logic [ADDR_W-1:0] pick_index();
      int roll;
      roll = $urandom_range(99, 0);
      if (plan_count != 0 && roll < 85) return ADDR_W'($urandom_range(plan_count - 1, 0));
      if (roll < 92 && plan_count < DEPTH) return ADDR_W'(plan_count);
      return ADDR_W'($urandom_range(DEPTH - 1, 0));
   endfunction

   function automatic void add_random_request(input int push_weight, input int pop_weight);
      logic [ACT_W-1:0]  act;
      logic [ADDR_W-1:0] ia;
      logic [ADDR_W-1:0] ib;
      logic [DATA_W-1:0] v;
      int roll;
      roll = $urandom_range(99, 0);
      if (roll < push_weight) begin
         act = ACT_PUSH;
      end else if (roll < push_weight + pop_weight) begin
         act = ACT_POP;
      end else if (roll >= 96) begin
         act = ACT_W'($urandom_range(7, 6));
      end else begin
         case ($urandom_range(3, 0))
            0: act = ACT_READ;
            1: act = ACT_WRITE;
            2: act = ACT_FIND;
            default: act = ACT_SWAP;
         endcase
      end
      ia = pick_index();
      ib = pick_index();
      if ($urandom_range(3, 0) != 0) v = hot_values[3'($urandom_range(7, 0))];
      else v = {$urandom, $urandom};
      add_request(act, ia, ib, v);
   endfunction

   // driver: request and limit write transactions, prediction on acceptance
   always @(posedge clock) begin : driver
      logic req_taken;
      logic csr_taken;
      logic rsp_taken;
      logic req_next;
      logic csr_next;
      pending_type head;
      stack_rsp_type predicted;
      if (!reset) begin
         req_taken = req_valid && req_ready;
         csr_taken = csr_valid && csr_ready;
         rsp_taken = rsp_valid && rsp_ready;
         if (req_taken) begin
            predicted = stack_apply({req_action, req_index_a, req_index_b, req_value});
            awaited_responses = {awaited_responses, predicted};
         end
         if (csr_taken) mirror_limit = csr_capacity_limit;
         open_requests = open_requests + int'(req_taken) - int'(rsp_taken);

         req_next = req_valid && !req_taken;
         csr_next = csr_valid && !csr_taken;
         if (!req_next && !csr_next && pending_items.size() != 0) begin
            head = pending_items[0];
            case (head.kind)
               ENTRY_MODE: begin
                  void'(pending_items.pop_front());
                  send_idle_pct <= head.send_idle;
                  recv_stall_pct <= head.recv_stall;
               end
               // limit writes only once every response is back
               ENTRY_CSR: begin
                  if (open_requests == 0) begin
                     void'(pending_items.pop_front());
                     csr_next = 1'b1;
                     csr_capacity_limit <= head.limit;
                  end
               end
               default: begin
                  if ($urandom_range(99, 0) >= send_idle_pct) begin
                     void'(pending_items.pop_front());
                     req_next = 1'b1;
                     req_action <= head.req.action;
                     req_index_a <= head.req.index_a;
                     req_index_b <= head.req.index_b;
                     req_value <= head.req.value;
                  end
               end
            endcase
         end
         req_valid <= req_next;
         csr_valid <= csr_next;
      end
   end

   // monitor: random back-pressure and field-by-field compare
   always @(posedge clock) begin : monitor
      stack_rsp_type want;
      rsp_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_responses.size() == 0) begin
            note_mismatch("response transaction with none awaited");
         end else begin
            want = awaited_responses.pop_front();
            if (rsp_read_value !== want.read_value)
               note_mismatch($sformatf("read_value got %h want %h",
                                       rsp_read_value, want.read_value));
            if (rsp_found !== want.found)
               note_mismatch($sformatf("found got %b want %b", rsp_found, want.found));
            if (rsp_found_index !== want.found_index)
               note_mismatch($sformatf("found_index got %0d want %0d",
                                       rsp_found_index, want.found_index));
            if (rsp_fill_count !== want.fill_count)
               note_mismatch($sformatf("fill_count got %0d want %0d",
                                       rsp_fill_count, want.fill_count));
            if (rsp_error !== want.error)
               note_mismatch($sformatf("error got %0d want %0d", rsp_error, want.error));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("indexed_stack_store_with_search test failed");
         $finish;
      end
   end

   initial begin
      logic [CNT_W-1:0] seg_limit [9];
      int seg_push [9];
      int seg_pop [9];
      int p;
      int s;
      int k;
      int h;

      foreach (mirror_words[i]) mirror_words[i] = '0;

      // directed: empty-store errors, first match, swaps, unused codes
      add_mode(7'd0, 7'd0);
      add_request(ACT_POP, 6'd0, 6'd0, '0);
      add_request(ACT_READ, 6'd0, 6'd0, '0);
      add_request(ACT_WRITE, 6'd0, 6'd0, 64'h1234_5678_9abc_def0);
      add_request(ACT_SWAP, 6'd0, 6'd0, '0);
      add_request(ACT_FIND, 6'd0, 6'd0, '0);
      add_request(ACT_PUSH, 6'd0, 6'd0, '1);
      add_request(ACT_PUSH, 6'd0, 6'd0, '0);
      add_request(ACT_PUSH, 6'd0, 6'd0, 64'h5555_5555_5555_5555);
      add_request(ACT_PUSH, 6'd0, 6'd0, '1);
      add_request(ACT_READ, 6'd0, 6'd0, '0);
      add_request(ACT_READ, 6'd63, 6'd0, '0);
      add_request(ACT_WRITE, 6'd1, 6'd0, 64'haaaa_aaaa_aaaa_aaaa);
      add_request(ACT_FIND, 6'd0, 6'd0, 64'haaaa_aaaa_aaaa_aaaa);
      add_request(ACT_FIND, 6'd0, 6'd0, '1);
      add_request(ACT_FIND, 6'd0, 6'd0, 64'h0123_4567_89ab_cdef);
      add_request(ACT_SWAP, 6'd0, 6'd2, '0);
      add_request(ACT_SWAP, 6'd1, 6'd4, '0);
      add_request(ACT_SWAP, 6'd3, 6'd3, '0);
      add_request(ACT_READ, 6'd2, 6'd0, '0);
      add_request(3'd6, 6'd63, 6'd63, '1);
      add_request(3'd7, 6'd0, 6'd0, '0);
      add_request(ACT_POP, 6'd0, 6'd0, '0);
      add_request(ACT_READ, 6'd3, 6'd0, '0);
      add_request(ACT_PUSH, 6'd63, 6'd63, {$urandom, $urandom});

      // limit settings and push/pop mix per segment
      seg_limit = '{7'd1, 7'd127, 7'd0, 7'd64, 7'd2, 7'($urandom_range(63, 3)),
                    7'($urandom_range(126, 65)), 7'd50, 7'd63};
      seg_push = '{25, 55, 10, 55, 20, 30, 55, 25, 10};
      seg_pop = '{20, 5, 40, 5, 30, 20, 5, 20, 40};

      // three idling phases of three segments each
      for (p = 0; p < 3; p++) begin
         case (p)
            0: add_mode(7'd20, 7'd59);
            1: add_mode(7'd59, 7'd20);
            default: add_mode(7'd0, 7'd0);
         endcase
         for (s = 0; s < 3; s++) begin
            k = p * 3 + s;
            add_limit(seg_limit[k]);
            hot_values[0] = '0;
            hot_values[1] = '1;
            hot_values[2] = 64'd1 << $urandom_range(63, 0);
            for (h = 3; h < 8; h++) hot_values[h] = {$urandom, $urandom};
            for (h = 0; h < SEGMENT_ITEMS; h++) add_random_request(seg_push[k], seg_pop[k]);
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // drain, then allow for the slowest find
      while (pending_items.size() != 0 || req_valid || csr_valid || open_requests != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (awaited_responses.size() != 0)
         note_mismatch($sformatf("%0d response transactions never arrived",
                                 awaited_responses.size()));

      if (mismatch_count == 0) begin
         $display("indexed_stack_store_with_search test passed");
      end else begin
         $display("indexed_stack_store_with_search test failed");
      end
      $finish;
   end

endmodule
